/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the stepper move generator.
// Each macro samples on clk; the first one is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled during reset
`define SMG_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define SMG_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/smg_pkg.sv */
// Types, constants and segment helpers of the stepper move generator.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package smg_pkg;

    localparam int OP_W      = 2;
    localparam int DEG_W     = 11;
    localparam int ANGLE_W   = 10;
    localparam int STEP_W    = 13;
    localparam int HP_W      = 16;
    localparam int LIMIT_W   = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_HOME = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_LIMIT = 1'b1;

    localparam logic [HP_W-1:0]    HP_RESET    = 16'd563;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd300;
    localparam logic [LIMIT_W-1:0] ANGLE_CAP   = 9'd300;
    localparam logic [STEP_W-1:0]  MAX_STEPS   = 13'h1FFF;

    // Scale of the reciprocal used for steps = |deg| * steps_per_rev / 360
    localparam int  RECIP_SHIFT = 20;
    localparam longint DEG_PER_REV = 360;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_MOVE = 4'b0010,
        MODE_HOME = 4'b0100,
        MODE_BACK = 4'b1000
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [STEP_W-1:0] steps;
        logic [HP_W-1:0]   hcnt;
        logic              phase;
        logic              dir;
    } motion_t;

    // Start a segment of n steps; the step pin goes high at once unless n is zero
    function automatic motion_t load_segment(motion_t st, logic [STEP_W-1:0] n, logic dir);
        motion_t r;
        r       = st;
        r.steps = n;
        r.dir   = dir;
        r.hcnt  = '0;
        r.phase = (n != '0);
        return r;
    endfunction

    // Decide what follows a finished segment
    function automatic motion_t end_segment(motion_t st, logic sw,
                                            logic [STEP_W-1:0] chunk,
                                            logic [STEP_W-1:0] backoff);
        motion_t r;
        r = st;
        if (st.mode == MODE_HOME) begin
            if (sw) begin
                r = load_segment(st, backoff, 1'b1);
                r.mode = (backoff == '0) ? MODE_IDLE : MODE_BACK;
            end
            else begin
                r = load_segment(st, chunk, 1'b0);
            end
        end
        else begin
            r = load_segment(st, '0, st.dir);
            r.mode = MODE_IDLE;
        end
        return r;
    endfunction

endpackage

/* rtl/smg_in_if.sv */
// Command channel of the stepper move generator: valid/ready plus item fields.
// Depends on smg_pkg for field widths.
`timescale 1ns / 1ps

interface smg_in_if;
    import smg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [DEG_W-1:0]  move_degrees;
    logic                     limit_switch;

    modport source (output valid, output operation, output move_degrees,
                    output limit_switch, input ready);
    modport sink   (input valid, input operation, input move_degrees,
                    input limit_switch, output ready);
endinterface

/* rtl/smg_out_if.sv */
// Result channel of the stepper move generator: valid/ready plus item fields.
// Depends on smg_pkg for field widths.
`timescale 1ns / 1ps

interface smg_out_if;
    import smg_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      step_out;
    logic                      direction_out;
    logic                      busy_res;
    logic                      rejected;
    logic signed [ANGLE_W-1:0] position_degrees;

    modport source (output valid, output step_out, output direction_out,
                    output busy_res, output rejected, output position_degrees,
                    input ready);
    modport sink   (input valid, input step_out, input direction_out,
                    input busy_res, input rejected, input position_degrees,
                    output ready);
endinterface

/* rtl/stepper_limited_move_generator.sv */
// Top level of the stepper step/direction generator with soft travel limit.
// Depends on smg_pkg, smg_in_if, smg_out_if and assert_macros.svh.
//
// Usage:
//   cmd carries one item per handshake: a time tick, a relative move in
//   degrees or a homing start. res returns exactly one item per command item
//   with the step and direction pin levels, busy flag, refusal flag and the
//   commanded table angle.
//   cfg_wr_en/cfg_index/cfg_data write the half period (index 0) and the
//   travel limit (index 1); write only while no item is in flight.
// Timing:
//   An accepted item lands in an input register and its result is loaded
//   into the output register once it is free, and is offered from there.
//   One item per cycle is sustained while res.ready stays high; the step
//   count is one constant multiply plus a shift, computed combinationally.
// Reset:
//   rst_n clears the valid bits of both pipeline registers, angle 0, motion
//   idle with phase and direction low, half period 563 and travel limit 300.
// Stall:
//   While res.ready is low the result is held; the input register still
//   takes one more item, then cmd.ready drops until the result drains.
`timescale 1ns / 1ps

module stepper_limited_move_generator #(
    parameter int STEPS_PER_REV      = 3200,
    parameter int HOMING_CHUNK_STEPS = 16,
    parameter int BACKOFF_STEPS      = 75
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [smg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [smg_pkg::HP_W-1:0]        cfg_data,
    smg_in_if.sink                          cmd,
    smg_out_if.source                       res
);
    import smg_pkg::*;

    `include "assert_macros.svh"

    // Reciprocal so that (mag * RECIP) >> RECIP_SHIFT == mag * STEPS_PER_REV / 360
    localparam longint RECIP   = ((longint'(STEPS_PER_REV) <<< RECIP_SHIFT)
                                  + DEG_PER_REV - 1) / DEG_PER_REV;
    localparam int     RECIP_W = $clog2(RECIP + 1);
    localparam int     PROD_W  = DEG_W + RECIP_W;
    localparam int     NFULL_W = PROD_W - RECIP_SHIFT;

    localparam logic [RECIP_W-1:0] RECIP_C   = RECIP_W'(RECIP);
    localparam logic [STEP_W-1:0]  CHUNK_C   = STEP_W'(HOMING_CHUNK_STEPS);
    localparam logic [STEP_W-1:0]  BACKOFF_C = STEP_W'(BACKOFF_STEPS);

    // Configuration
    logic [HP_W-1:0]    half_period_reg;
    logic [LIMIT_W-1:0] travel_limit_reg;

    // Input register
    logic                    in_valid_reg;
    logic [OP_W-1:0]         in_op_reg;
    logic signed [DEG_W-1:0] in_deg_reg;
    logic                    in_sw_reg;

    // Block state
    motion_t                   motion_reg, motion_next;
    logic signed [ANGLE_W-1:0] angle_reg, angle_next;

    // Output register
    logic                      out_valid_reg;
    logic                      out_step_reg;
    logic                      out_dir_reg;
    logic                      out_busy_reg;
    logic                      out_rej_reg;
    logic signed [ANGLE_W-1:0] out_angle_reg;

    logic advance;
    logic rej;

    // Move arithmetic
    logic [LIMIT_W-1:0]         lim;
    logic signed [ANGLE_W+1:0]  lim_pos, lim_neg, target;
    logic                       out_of_range;
    logic [DEG_W-1:0]           mag;
    logic [PROD_W-1:0]          prod;
    logic [NFULL_W-1:0]         n_full;
    logic [STEP_W-1:0]          move_steps;
    logic                       move_cw;

    // Tick arithmetic
    logic [HP_W-1:0] hp_eff;
    logic [HP_W-1:0] hcnt_inc;

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || advance;

    always_comb
    begin
        lim          = (travel_limit_reg > ANGLE_CAP) ? ANGLE_CAP : travel_limit_reg;
        lim_pos      = signed'({3'b000, lim});
        lim_neg      = -lim_pos;
        target       = (ANGLE_W+2)'(angle_reg) + (ANGLE_W+2)'(in_deg_reg);
        out_of_range = (target > lim_pos) || (target < lim_neg);
        mag          = in_deg_reg[DEG_W-1] ? DEG_W'(-in_deg_reg) : DEG_W'(in_deg_reg);
        prod         = PROD_W'(mag) * PROD_W'(RECIP_C);
        n_full       = NFULL_W'(prod >> RECIP_SHIFT);
        move_steps   = (n_full > NFULL_W'(MAX_STEPS)) ? MAX_STEPS : STEP_W'(n_full);
        move_cw      = !in_deg_reg[DEG_W-1] && (in_deg_reg != '0);
        hp_eff       = (half_period_reg == '0) ? HP_W'(1) : half_period_reg;
        hcnt_inc     = motion_reg.hcnt + HP_W'(1);
    end

    always_comb
    begin
        motion_next = motion_reg;
        angle_next  = angle_reg;
        rej         = 1'b0;
        case (in_op_reg)
            OP_MOVE:
            begin
                if (motion_reg.mode != MODE_IDLE || out_of_range) begin
                    rej = 1'b1;
                end
                else begin
                    angle_next       = ANGLE_W'(target);
                    motion_next      = load_segment(motion_reg, move_steps, move_cw);
                    motion_next.mode = (move_steps != '0) ? MODE_MOVE : MODE_IDLE;
                end
            end
            OP_HOME:
            begin
                if (motion_reg.mode != MODE_IDLE) begin
                    rej = 1'b1;
                end
                else begin
                    motion_next      = motion_reg;
                    motion_next.mode = MODE_HOME;
                    motion_next      = end_segment(motion_next, in_sw_reg, CHUNK_C, BACKOFF_C);
                end
            end
            default:
            begin
                // Time tick (unused code acts as one)
                if (motion_reg.mode == MODE_IDLE) begin
                    motion_next = motion_reg;
                end
                else if (motion_reg.steps == '0) begin
                    motion_next = end_segment(motion_reg, in_sw_reg, CHUNK_C, BACKOFF_C);
                end
                else if (hcnt_inc < hp_eff && hcnt_inc != '0) begin
                    motion_next.hcnt = hcnt_inc;
                end
                else begin
                    motion_next.hcnt = '0;
                    if (motion_reg.phase) begin
                        motion_next.phase = 1'b0;
                    end
                    else begin
                        motion_next.steps = motion_reg.steps - STEP_W'(1);
                        if (motion_next.steps != '0) begin
                            motion_next.phase = 1'b1;
                        end
                        else begin
                            motion_next = end_segment(motion_next, in_sw_reg,
                                                      CHUNK_C, BACKOFF_C);
                        end
                    end
                end
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            half_period_reg  <= HP_RESET;
            travel_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HALF_PERIOD:  half_period_reg  <= cfg_data;
                CFG_TRAVEL_LIMIT: travel_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:          half_period_reg  <= half_period_reg;
            endcase
        end
    end

    // Control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            motion_reg.mode  <= MODE_IDLE;
            motion_reg.steps <= '0;
            motion_reg.hcnt  <= '0;
            motion_reg.phase <= 1'b0;
            motion_reg.dir   <= 1'b0;
            angle_reg        <= '0;
        end
        else begin
            if (cmd.valid && cmd.ready) begin
                in_valid_reg <= 1'b1;
            end
            else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                motion_reg    <= motion_next;
                angle_reg     <= angle_next;
            end
            else if (res.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready) begin
            in_op_reg  <= cmd.operation;
            in_deg_reg <= cmd.move_degrees;
            in_sw_reg  <= cmd.limit_switch;
        end
        if (advance) begin
            out_step_reg  <= motion_next.phase;
            out_dir_reg   <= motion_next.dir;
            out_busy_reg  <= (motion_next.mode != MODE_IDLE);
            out_rej_reg   <= rej;
            out_angle_reg <= angle_next;
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.step_out         = out_step_reg;
    assign res.direction_out    = out_dir_reg;
    assign res.busy_res         = out_busy_reg;
    assign res.rejected         = out_rej_reg;
    assign res.position_degrees = out_angle_reg;

    `SMG_ASSERT_ALWAYS(a_idle_clear,
        (motion_reg.mode == MODE_IDLE) |-> (motion_reg.steps == '0 && !motion_reg.phase),
        "idle motion with steps pending or step pin high")
    `SMG_ASSERT_ALWAYS(a_phase_needs_steps,
        motion_reg.phase |-> (motion_reg.steps != '0),
        "step pin high with no step left")
    `SMG_ASSERT(a_angle_range,
        (angle_reg <= signed'(ANGLE_W'(ANGLE_CAP)))
            && (angle_reg >= -signed'(ANGLE_W'(ANGLE_CAP))),
        "table angle outside the travel cap")
    `SMG_ASSERT(a_result_from_item,
        $rose(out_valid_reg) |-> $past(in_valid_reg),
        "result produced without a pending item")
    `SMG_ASSERT(a_state_only_on_advance,
        !advance |=> ($stable(angle_reg) && $stable(motion_reg)),
        "state changed without an item advancing")

endmodule
